>>> hdl/pst_pkg.sv
// Package for the per-peer sequence tracker: sizes, parser phases, result status codes
// and the layout of one peer record in the tracking memory.
// No dependencies.
package pst_pkg;

    localparam int MAX_PEERS = 1024;
    localparam int PEER_W    = 10;
    localparam int IDX_W     = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int SEQ_W     = 31;
    localparam int STATUS_W  = 3;

    localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

    typedef enum logic [3:0] {
        PH_S,
        PH_E,
        PH_Q,
        PH_COLON,
        PH_LEAD,
        PH_SIGNED,
        PH_DIGITS,
        PH_OK,
        PH_BAD
    } parse_phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NOT_CHECKED,
        ST_FIRST,
        ST_IN_ORDER,
        ST_GAP,
        ST_DUPLICATE,
        ST_REGRESSION
    } seq_status_t;

    typedef struct packed {
        logic             seen;
        logic [SEQ_W-1:0] latest_seq;
        logic [SEQ_W-1:0] dups;
        logic [SEQ_W-1:0] gaps;
        logic [SEQ_W-1:0] regs;
    } peer_rec_t;

endpackage

>>> hdl/per_peer_sequence_tracker_unit.sv
// Per-peer sequence tracker: byte parser, peer record memory with read-modify-write,
// and the registered result channel.
// Depends on pst_pkg.
//
// Usage:
//   s_ channel: one transfer per payload byte (s_cmd = 0) tagged with s_peer, s_last_byte
//   marking the final byte; s_cmd = 1 clears the record of s_peer and gives no result.
//   m_ channel: one result per last byte, nothing for other bytes or clears.
//   cfg_ channel: writes seq_check_enable; always ready; write it while the block is idle.
// Throughput: one s_ transfer per cycle, sustained, for any mix of peers, while the
//   output register is free. The record memory has one read and one write port; a
//   back-to-back message or clear on the same peer is served by forwarding the
//   write-back data into the read stage. A last byte enters the update stage with its
//   memory read; the output register is loaded from it once that register is free.
// Reset: synchronous, active low. After reset the record memory is swept, one entry per
//   cycle, for MAX_PEERS (1024) entries; s_ready is low meanwhile, cfg_ stays open.
// Stall: the output register holds a result until m_ready; while it is full and not
//   taken, a waiting last byte holds in the update stage and s_ready drops. A clear
//   never waits on the output register.
module per_peer_sequence_tracker_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_seq_check_enable,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_cmd,
    input  logic [pst_pkg::PEER_W-1:0]  s_peer,
    input  logic [7:0]                  s_data_byte,
    input  logic                        s_last_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pst_pkg::STATUS_W-1:0] m_status,
    output logic [pst_pkg::SEQ_W-1:0]   m_seq_value,
    output logic [pst_pkg::SEQ_W-1:0]   m_missing_count,
    output logic [pst_pkg::SEQ_W-1:0]   m_previous_seq,
    output logic [pst_pkg::SEQ_W-1:0]   m_duplicate_total,
    output logic [pst_pkg::SEQ_W-1:0]   m_gap_total,
    output logic [pst_pkg::SEQ_W-1:0]   m_regression_total
);
    import pst_pkg::*;

    // configuration
    logic enable_reg;

    // init sweep
    logic [IDX_W-1:0] init_cnt_reg, init_cnt_next;
    logic             init_done_reg, init_done_next;

    // parser
    parse_phase_t     phase_reg, phase_next, step_phase;
    logic [SEQ_W-1:0] acc_reg, acc_next, step_acc;
    logic             neg_reg, neg_next, step_neg;
    logic             ovf_reg, ovf_next, step_ovf;
    logic             is_digit, is_space;
    logic [SEQ_W+3:0] acc_x10;
    logic             digit_ovf;

    // handshake
    logic             accept, s1_take, s1_go, s1_free, out_free;
    logic [IDX_W-1:0] peer_idx;
    logic             in_range, chk;

    // update stage
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_clear_reg, s1_chk_reg, s1_in_range_reg;
    logic [IDX_W-1:0] s1_addr_reg;
    logic [SEQ_W-1:0] s1_seq_reg;
    peer_rec_t        rd_rec_reg, fwd_rec_reg, cur_rec, new_rec;
    logic             fwd_hit_reg;
    logic             s1_wr;
    seq_status_t      res_status;
    logic [SEQ_W-1:0] res_missing, res_prev;
    logic [SEQ_W-1:0] missing;
    logic [SEQ_W:0]   gap_sum;

    // memory port
    peer_rec_t        mem [MAX_PEERS];
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    peer_rec_t        wr_data;

    // output register
    logic             m_valid_reg, m_valid_next;
    seq_status_t      out_status_reg;
    logic [SEQ_W-1:0] out_seq_reg, out_missing_reg, out_prev_reg;
    logic [SEQ_W-1:0] out_dup_reg, out_gap_reg, out_regr_reg;

    assign cfg_ready = 1'b1;

    assign out_free = !m_valid_reg || m_ready;
    assign s1_go    = s1_valid_reg && (s1_clear_reg || out_free);
    assign s1_free  = !s1_valid_reg || s1_go;
    assign s_ready  = init_done_reg && s1_free;
    assign accept   = s_valid && s_ready;
    assign s1_take  = accept && (s_cmd || s_last_byte);
    assign peer_idx = IDX_W'(s_peer);
    assign in_range = (32'(s_peer) < 32'(MAX_PEERS));

    // ---------------- init sweep ----------------
    always_comb begin
        init_cnt_next  = init_cnt_reg;
        init_done_next = init_done_reg;
        if (!init_done_reg) begin
            init_cnt_next = init_cnt_reg + 1'b1;
            if (init_cnt_reg == IDX_W'(MAX_PEERS - 1)) begin
                init_done_next = 1'b1;
            end
        end
    end

    // ---------------- parser ----------------
    always_comb begin
        is_digit  = (s_data_byte >= 8'h30) && (s_data_byte <= 8'h39);
        is_space  = (s_data_byte == 8'h20) || ((s_data_byte >= 8'h09) && (s_data_byte <= 8'h0D));
        // acc * 10 + digit; the low nibble of an ASCII digit is its value
        acc_x10   = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                  + {{(SEQ_W){1'b0}}, s_data_byte[3:0]};
        digit_ovf = (acc_x10 > {4'b0, SEQ_MAX});

        step_phase = phase_reg;
        step_acc   = acc_reg;
        step_neg   = neg_reg;
        step_ovf   = ovf_reg;
        case (phase_reg)
            PH_S:     step_phase = (s_data_byte == 8'h53) ? PH_E : PH_BAD;
            PH_E:     step_phase = (s_data_byte == 8'h45) ? PH_Q : PH_BAD;
            PH_Q:     step_phase = (s_data_byte == 8'h51) ? PH_COLON : PH_BAD;
            PH_COLON: step_phase = (s_data_byte == 8'h3A) ? PH_LEAD : PH_BAD;
            PH_LEAD: begin
                if (is_space) begin
                    step_phase = PH_LEAD;
                end else if (s_data_byte == 8'h2B) begin
                    step_phase = PH_SIGNED;
                end else if (s_data_byte == 8'h2D) begin
                    step_neg   = 1'b1;
                    step_phase = PH_SIGNED;
                end else if (is_digit) begin
                    step_phase = PH_DIGITS;
                end else begin
                    step_phase = PH_BAD;
                end
            end
            PH_SIGNED: step_phase = is_digit ? PH_DIGITS : PH_BAD;
            PH_DIGITS: begin
                if (!is_digit) begin
                    step_phase = (s_data_byte == 8'h3A) ? PH_OK : PH_BAD;
                end
            end
            PH_OK:   step_phase = PH_OK;
            default: step_phase = PH_BAD;
        endcase

        // digit accumulation; sticks once overflowed
        if (is_digit && !ovf_reg &&
            (phase_reg == PH_LEAD || phase_reg == PH_SIGNED || phase_reg == PH_DIGITS)) begin
            if (digit_ovf) begin
                step_ovf = 1'b1;
            end else begin
                step_acc = acc_x10[SEQ_W-1:0];
            end
        end

        // reaching PH_OK adds no digit, so the held number is final
        chk = (step_phase == PH_OK) && !ovf_reg && !(neg_reg && (acc_reg != '0)) &&
              enable_reg && in_range;

        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        if (accept && !s_cmd) begin
            if (s_last_byte) begin
                phase_next = PH_S;
                acc_next   = '0;
                neg_next   = 1'b0;
                ovf_next   = 1'b0;
            end else begin
                phase_next = step_phase;
                acc_next   = step_acc;
                neg_next   = step_neg;
                ovf_next   = step_ovf;
            end
        end
    end

    // ---------------- update stage ----------------
    always_comb begin
        cur_rec     = fwd_hit_reg ? fwd_rec_reg : rd_rec_reg;
        new_rec     = cur_rec;
        s1_wr       = 1'b0;
        res_status  = ST_NOT_CHECKED;
        res_missing = '0;
        res_prev    = '0;
        missing     = s1_seq_reg - cur_rec.latest_seq - 1'b1;
        gap_sum     = {1'b0, cur_rec.gaps} + {1'b0, missing};

        if (s1_clear_reg) begin
            new_rec = '0;
            s1_wr   = s1_in_range_reg;
        end else if (s1_chk_reg) begin
            s1_wr = 1'b1;
            if (!cur_rec.seen) begin
                new_rec.seen       = 1'b1;
                new_rec.latest_seq = s1_seq_reg;
                res_status         = ST_FIRST;
            end else begin
                res_prev = cur_rec.latest_seq;
                if (s1_seq_reg == cur_rec.latest_seq) begin
                    if (cur_rec.dups != SEQ_MAX) begin
                        new_rec.dups = cur_rec.dups + 1'b1;
                    end
                    res_status = ST_DUPLICATE;
                end else if (s1_seq_reg < cur_rec.latest_seq) begin
                    if (cur_rec.regs != SEQ_MAX) begin
                        new_rec.regs = cur_rec.regs + 1'b1;
                    end
                    new_rec.latest_seq = s1_seq_reg;
                    res_status         = ST_REGRESSION;
                end else begin
                    new_rec.latest_seq = s1_seq_reg;
                    if (missing != '0) begin
                        res_missing  = missing;
                        new_rec.gaps = gap_sum[SEQ_W] ? SEQ_MAX : gap_sum[SEQ_W-1:0];
                        res_status   = ST_GAP;
                    end else begin
                        res_status = ST_IN_ORDER;
                    end
                end
            end
        end

        wr_en   = !init_done_reg || (s1_go && s1_wr);
        wr_addr = init_done_reg ? s1_addr_reg : init_cnt_reg;
        wr_data = init_done_reg ? new_rec : '0;

        s1_valid_next = s1_valid_reg;
        if (s1_take) begin
            s1_valid_next = 1'b1;
        end else if (s1_go) begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (s1_go && !s1_clear_reg) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // record memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (s1_take) begin
            rd_rec_reg <= mem[peer_idx];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            init_cnt_reg  <= '0;
            init_done_reg <= 1'b0;
            phase_reg     <= PH_S;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                enable_reg <= cfg_seq_check_enable;
            end
            init_cnt_reg  <= init_cnt_next;
            init_done_reg <= init_done_next;
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            ovf_reg       <= ovf_next;
            s1_valid_reg  <= s1_valid_next;
            m_valid_reg   <= m_valid_next;
            if (s1_take) begin
                // same entry written back in this cycle: take the new record
                fwd_hit_reg <= wr_en && (wr_addr == peer_idx);
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s1_take) begin
            s1_clear_reg    <= s_cmd;
            s1_chk_reg      <= chk;
            s1_in_range_reg <= in_range;
            s1_addr_reg     <= peer_idx;
            s1_seq_reg      <= acc_reg;
            fwd_rec_reg     <= wr_data;
        end
        if (s1_go && !s1_clear_reg) begin
            out_status_reg  <= res_status;
            out_seq_reg     <= s1_chk_reg ? s1_seq_reg : '0;
            out_missing_reg <= res_missing;
            out_prev_reg    <= res_prev;
            out_dup_reg     <= s1_chk_reg ? new_rec.dups : '0;
            out_gap_reg     <= s1_chk_reg ? new_rec.gaps : '0;
            out_regr_reg    <= s1_chk_reg ? new_rec.regs : '0;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = out_status_reg;
    assign m_seq_value        = out_seq_reg;
    assign m_missing_count    = out_missing_reg;
    assign m_previous_seq     = out_prev_reg;
    assign m_duplicate_total  = out_dup_reg;
    assign m_gap_total        = out_gap_reg;
    assign m_regression_total = out_regr_reg;

`ifndef SYNTHESIS
    a_no_traffic_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done_reg |-> (!s1_valid_reg && !m_valid_reg))
        else $error("pipeline active during memory sweep");

    a_fwd_needs_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg && !s1_valid_reg |=> !s1_valid_reg || $past(s1_take))
        else $error("forwarded record without a stage transfer");

    a_read_held_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_go |=> $stable(rd_rec_reg) && $stable(s1_addr_reg))
        else $error("update stage lost its read data while stalled");

    a_not_checked_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (out_status_reg == ST_NOT_CHECKED) |->
        (out_seq_reg == '0) && (out_dup_reg == '0) && (out_gap_reg == '0) &&
        (out_regr_reg == '0))
        else $error("unchecked result carries data");

    a_missing_only_on_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((out_status_reg == ST_GAP) == (out_missing_reg != '0)))
        else $error("missing count inconsistent with status");
`endif

endmodule
